// ===== hw/rtl/sorted_breakpoint_blend_lookup_assert.svh =====
// Assertion macros for the breakpoint lookup block
`ifndef SORTED_BREAKPOINT_BLEND_LOOKUP_ASSERT_SVH
`define SORTED_BREAKPOINT_BLEND_LOOKUP_ASSERT_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define SBBL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that is also checked while reset is applied
`define SBBL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sbbl_pkg.sv =====
// Shared constants for the sorted breakpoint blend lookup
package sbbl_pkg;
    localparam int MAX_ENTRIES_DEF      = 32;
    localparam int HANDLE_BITS_DEF      = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    localparam int KEY_W    = 32;
    localparam int IN_HDL_W = 16;
    localparam int SLOT_W   = 6;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_QUERY  = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_REPLACED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    localparam logic [1:0] NCNT_NONE   = 2'd0;
    localparam logic [1:0] NCNT_ONE    = 2'd1;
    localparam logic [1:0] NCNT_TWO    = 2'd2;
endpackage

// ===== hw/rtl/sbbl_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module sbbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/sorted_breakpoint_blend_lookup.sv =====
// Sorted breakpoint table with bracketing lookup and blend weight
//
// Input stream s_*: one transaction per operation (add, remove by index,
// clear, query). Output stream m_*: exactly one result transaction per
// operation, in order. Operations run one at a time; s_tready is high
// while the sequencer is idle.
// Operation steps, paced by the single memory port (read, then evaluate or
// write); s_tready rises with m_tvalid:
//   clear, ignored add/remove, empty query: straight to the response
//   add: a read and compare per entry scanned, a read and write per entry
//        moved up, then the write, if any, and the response
//   remove: a read and write per entry moved down, then the response
//   query: a read and compare per entry scanned, plus WEIGHT_FRAC_BITS
//        divide steps when two entries bracket the key
// Reset empties the table at once (fill count to zero); no memory sweep.
// A stalled result is held in the output register; the next operation may
// be taken meanwhile and its result waits until the register frees.
module sorted_breakpoint_blend_lookup
    import sbbl_pkg::*;
#(
    parameter int MAX_ENTRIES      = MAX_ENTRIES_DEF,
    parameter int HANDLE_BITS      = HANDLE_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
    localparam int IW    = $clog2(MAX_ENTRIES),
    localparam int FW    = IW + 1,
    localparam int IN_W  = 2 + KEY_W + IN_HDL_W + 1 + SLOT_W,
    localparam int IN_TW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W = 2 + 2 + 2 * IW + 2 * HANDLE_BITS + WEIGHT_FRAC_BITS + 1 + FW,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // func, key_value, clip_handle, clip_present, slot_index
    input  logic [IN_TW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // status, neighbor_count, low_index, high_index, low_clip, high_clip,
    // blend_weight, entry_count
    output logic [OUT_TW-1:0] m_tdata
);
    localparam int MW  = KEY_W + HANDLE_BITS;
    localparam int CW  = (FW > SLOT_W) ? FW : SLOT_W;
    localparam int DCW = $clog2(WEIGHT_FRAC_BITS);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN_RD  = 7'b0000010,
        S_SCAN_EV  = 7'b0000100,
        S_SHIFT_RD = 7'b0001000,
        S_SHIFT_WR = 7'b0010000,
        S_DIV      = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]                 func_reg, func_next;
    logic [KEY_W-1:0]           key_reg, key_next;
    logic [HANDLE_BITS-1:0]     hdl_reg, hdl_next;
    logic [FW-1:0]              fill_reg, fill_next;
    logic [FW-1:0]              idx_reg, idx_next;
    logic [FW-1:0]              ins_reg, ins_next;
    logic [KEY_W-1:0]           pkey_reg, pkey_next;
    logic [HANDLE_BITS-1:0]     pclip_reg, pclip_next;
    logic [1:0]                 status_reg, status_next;
    logic [1:0]                 ncnt_reg, ncnt_next;
    logic [IW-1:0]              lo_reg, lo_next, hi_reg, hi_next;
    logic [HANDLE_BITS-1:0]     lclip_reg, lclip_next, hclip_reg, hclip_next;
    logic [KEY_W+1:0]           rem_reg, rem_next;
    logic [KEY_W:0]             den_reg, den_next;
    logic [WEIGHT_FRAC_BITS-1:0] quo_reg, quo_next;
    logic [DCW-1:0]             cnt_reg, cnt_next;
    logic                       m_valid_reg, m_valid_next;
    logic [OUT_TW-1:0]          m_data_reg, m_data_next;

    logic                   mem_we;
    logic [IW-1:0]          mem_waddr, mem_raddr;
    logic [MW-1:0]          mem_wdata, mem_rdata;
    logic [KEY_W-1:0]       rd_key;
    logic [HANDLE_BITS-1:0] rd_clip;
    logic [1:0]             in_func;
    logic [KEY_W-1:0]       in_key;
    logic [IN_HDL_W-1:0]    in_hdl;
    logic                   in_present;
    logic [SLOT_W-1:0]      in_slot;
    logic [KEY_W+1:0]       div_shift;
    logic                   s_fire;

    sbbl_ram #(.WIDTH(MW), .DEPTH(MAX_ENTRIES)) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_func    = s_tdata[1:0];
    assign in_key     = s_tdata[2 +: KEY_W];
    assign in_hdl     = s_tdata[2 + KEY_W +: IN_HDL_W];
    assign in_present = s_tdata[2 + KEY_W + IN_HDL_W];
    assign in_slot    = s_tdata[3 + KEY_W + IN_HDL_W +: SLOT_W];
    assign rd_key     = mem_rdata[MW-1 -: KEY_W];
    assign rd_clip    = mem_rdata[HANDLE_BITS-1:0];
    assign s_tready   = (state_reg == S_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign div_shift  = {rem_reg[KEY_W:0], 1'b0};

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        key_next     = key_reg;
        hdl_next     = hdl_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        ins_next     = ins_reg;
        pkey_next    = pkey_reg;
        pclip_next   = pclip_reg;
        status_next  = status_reg;
        ncnt_next    = ncnt_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        lclip_next   = lclip_reg;
        hclip_next   = hclip_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg[IW-1:0];
        mem_wdata    = mem_rdata;
        mem_raddr    = idx_reg[IW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    func_next   = in_func;
                    key_next    = in_key;
                    hdl_next    = HANDLE_BITS'(in_hdl);
                    status_next = ST_DONE;
                    ncnt_next   = NCNT_NONE;
                    lo_next     = '0;
                    hi_next     = '0;
                    lclip_next  = '0;
                    hclip_next  = '0;
                    quo_next    = '0;
                    idx_next    = '0;
                    state_next  = S_RESP;
                    unique case (in_func)
                        FUNC_ADD: begin
                            if (in_present) begin
                                state_next = S_SCAN_RD;
                            end else begin
                                status_next = ST_IGNORED;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (CW'(in_slot) < CW'(fill_reg)) begin
                                idx_next   = FW'(in_slot);
                                state_next = S_SHIFT_RD;
                            end else begin
                                status_next = ST_IGNORED;
                            end
                        end
                        FUNC_CLEAR: begin
                            fill_next = '0;
                        end
                        FUNC_QUERY: begin
                            if (fill_reg != '0) begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (idx_reg == fill_reg) begin
                    if (func_reg == FUNC_ADD) begin
                        if (fill_reg == FW'(MAX_ENTRIES)) begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end else begin
                            ins_next   = fill_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end else begin
                        ncnt_next  = NCNT_ONE;
                        lo_next    = IW'(fill_reg - 1'b1);
                        hi_next    = IW'(fill_reg - 1'b1);
                        lclip_next = pclip_reg;
                        hclip_next = pclip_reg;
                        state_next = S_RESP;
                    end
                end else begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (func_reg == FUNC_ADD) begin
                    if (rd_key == key_reg) begin
                        mem_we      = 1'b1;
                        mem_wdata   = {key_reg, hdl_reg};
                        status_next = ST_REPLACED;
                        state_next  = S_RESP;
                    end else if ($signed(rd_key) > $signed(key_reg)) begin
                        if (fill_reg == FW'(MAX_ENTRIES)) begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end else begin
                            ins_next   = idx_reg;
                            idx_next   = fill_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCAN_RD;
                    end
                end else begin
                    if ($signed(rd_key) >= $signed(key_reg)) begin
                        if (idx_reg == '0 || rd_key == key_reg) begin
                            ncnt_next  = NCNT_ONE;
                            lo_next    = idx_reg[IW-1:0];
                            hi_next    = idx_reg[IW-1:0];
                            lclip_next = rd_clip;
                            hclip_next = rd_clip;
                            state_next = S_RESP;
                        end else begin
                            ncnt_next  = NCNT_TWO;
                            lo_next    = IW'(idx_reg - 1'b1);
                            hi_next    = idx_reg[IW-1:0];
                            lclip_next = pclip_reg;
                            hclip_next = rd_clip;
                            rem_next   = {1'b0, {key_reg[KEY_W-1], key_reg} -
                                                {pkey_reg[KEY_W-1], pkey_reg}};
                            den_next   = {rd_key[KEY_W-1], rd_key} -
                                         {pkey_reg[KEY_W-1], pkey_reg};
                            cnt_next   = '0;
                            state_next = S_DIV;
                        end
                    end else begin
                        pkey_next  = rd_key;
                        pclip_next = rd_clip;
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SHIFT_RD: begin
                if (func_reg == FUNC_ADD) begin
                    if (idx_reg == ins_reg) begin
                        mem_we     = 1'b1;
                        mem_wdata  = {key_reg, hdl_reg};
                        fill_next  = fill_reg + 1'b1;
                        state_next = S_RESP;
                    end else begin
                        mem_raddr  = IW'(idx_reg - 1'b1);
                        state_next = S_SHIFT_WR;
                    end
                end else begin
                    if ((idx_reg + 1'b1) >= fill_reg) begin
                        fill_next  = fill_reg - 1'b1;
                        state_next = S_RESP;
                    end else begin
                        mem_raddr  = IW'(idx_reg + 1'b1);
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR: begin
                mem_we = 1'b1;
                if (func_reg == FUNC_ADD) begin
                    idx_next = idx_reg - 1'b1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
                state_next = S_SHIFT_RD;
            end
            S_DIV: begin
                if (div_shift >= {1'b0, den_reg}) begin
                    rem_next = div_shift - {1'b0, den_reg};
                    quo_next = {quo_reg[WEIGHT_FRAC_BITS-2:0], 1'b1};
                end else begin
                    rem_next = div_shift;
                    quo_next = {quo_reg[WEIGHT_FRAC_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCW'(WEIGHT_FRAC_BITS - 1)) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_TW'({fill_reg, 1'b0, quo_reg, hclip_reg, lclip_reg,
                                            hi_reg, lo_reg, ncnt_reg, status_reg});
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg   <= func_next;
        key_reg    <= key_next;
        hdl_reg    <= hdl_next;
        idx_reg    <= idx_next;
        ins_reg    <= ins_next;
        pkey_reg   <= pkey_next;
        pclip_reg  <= pclip_next;
        status_reg <= status_next;
        ncnt_reg   <= ncnt_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        lclip_reg  <= lclip_next;
        hclip_reg  <= hclip_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end
endmodule

// ===== hw/rtl/sbbl_chk.sv =====
// Port-level checker for the breakpoint lookup block, bound to the top level
`include "sorted_breakpoint_blend_lookup_assert.svh"

module sbbl_chk
    import sbbl_pkg::*;
#(
    parameter int MAX_ENTRIES      = MAX_ENTRIES_DEF,
    parameter int HANDLE_BITS      = HANDLE_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
    parameter int IN_TW            = 64,
    parameter int OUT_TW           = 72
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [IN_TW-1:0]  s_tdata,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_TW-1:0] m_tdata
);
    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int FW   = IW + 1;
    localparam int WOFF = 4 + 2 * IW + 2 * HANDLE_BITS;
    localparam int COFF = WOFF + WEIGHT_FRAC_BITS + 1;

    logic [1:0]                ncnt;
    logic [WEIGHT_FRAC_BITS:0] weight;
    logic [FW-1:0]             count;

    assign ncnt   = m_tdata[3:2];
    assign weight = m_tdata[WOFF +: WEIGHT_FRAC_BITS + 1];
    assign count  = m_tdata[COFF +: FW];

    `SBBL_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `SBBL_ASSERT(a_in_hold, aclk, aresetn, s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata), "waiting transaction changed")
    `SBBL_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `SBBL_ASSERT(a_count_range, aclk, aresetn, m_tvalid |-> count <= FW'(MAX_ENTRIES) && ncnt != 2'd3, "entry count or neighbor count out of range")
    `SBBL_ASSERT(a_weight_only_blend, aclk, aresetn, m_tvalid && ncnt != NCNT_TWO |-> weight == '0, "weight without two neighbors")
endmodule

bind sorted_breakpoint_blend_lookup sbbl_chk #(
    .MAX_ENTRIES      (MAX_ENTRIES),
    .HANDLE_BITS      (HANDLE_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .IN_TW            (IN_TW),
    .OUT_TW           (OUT_TW)
) u_sbbl_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sorted_breakpoint_blend_lookup_tb.sv =====
// Testbench for the sorted breakpoint blend lookup: directed table plus random ops
`timescale 1ns / 1ps

module sorted_breakpoint_blend_lookup_tb;
    import sbbl_pkg::*;

    localparam int NE     = MAX_ENTRIES_DEF;
    localparam int IN_W   = 2 + KEY_W + IN_HDL_W + 1 + SLOT_W;
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W  = 2 + 2 + 5 + 5 + 16 + 16 + 17 + 6;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam int N_DIR  = 22;

    typedef struct packed {
        logic [5:0]  slot;
        logic        present;
        logic [15:0] handle;
        logic [31:0] key;
        logic [1:0]  func;
    } op_t;

    typedef struct packed {
        logic [5:0]  count;
        logic [16:0] weight;
        logic [15:0] hclip;
        logic [15:0] lclip;
        logic [4:0]  hidx;
        logic [4:0]  lidx;
        logic [1:0]  ncnt;
        logic [1:0]  status;
    } res_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_TW-1:0]  s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_TW-1:0] m_tdata;

    sorted_breakpoint_blend_lookup u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    logic signed [31:0] bp_key [NE];
    logic [15:0]        bp_clip [NE];
    int                 bp_fill;
    res_t               pending_results [$];
    int                 errors = 0;
    int                 send_idle = 0;
    int                 recv_stall = 0;
    bit                 hold_off = 0;

    function automatic res_t lookup_predict(op_t op);
        res_t r;
        logic signed [31:0] k;
        int h;
        int found;
        logic [63:0] num, den, w;
        r = '0;
        k = op.key;
        case (op.func)
            FUNC_ADD: begin
                if (!op.present) begin
                    r.status = ST_IGNORED;
                end else begin
                    found = -1;
                    for (int i = 0; i < bp_fill; i++)
                        if (found < 0 && bp_key[i] == k) found = i;
                    if (found >= 0) begin
                        bp_clip[found] = op.handle;
                        r.status = ST_REPLACED;
                    end else if (bp_fill >= NE) begin
                        r.status = ST_FULL;
                    end else begin
                        h = bp_fill;
                        while (h > 0 && bp_key[h-1] > k) begin
                            bp_key[h] = bp_key[h-1];
                            bp_clip[h] = bp_clip[h-1];
                            h--;
                        end
                        bp_key[h] = k;
                        bp_clip[h] = op.handle;
                        bp_fill++;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (op.slot < bp_fill) begin
                    for (int i = op.slot; i + 1 < bp_fill; i++) begin
                        bp_key[i] = bp_key[i+1];
                        bp_clip[i] = bp_clip[i+1];
                    end
                    bp_fill--;
                end else begin
                    r.status = ST_IGNORED;
                end
            end
            FUNC_CLEAR: bp_fill = 0;
            default: begin
                if (bp_fill > 0) begin
                    r.ncnt = NCNT_ONE;
                    if (bp_fill == 1 || k <= bp_key[0]) begin
                        r.lidx = '0;
                        r.hidx = '0;
                    end else if (k >= bp_key[bp_fill-1]) begin
                        r.lidx = 5'(bp_fill - 1);
                        r.hidx = 5'(bp_fill - 1);
                    end else begin
                        h = 0;
                        while (h < bp_fill - 1 && bp_key[h] < k) h++;
                        r.lidx = 5'(h);
                        r.hidx = 5'(h);
                        if (bp_key[h] != k) begin
                            r.lidx = 5'(h - 1);
                            r.ncnt = NCNT_TWO;
                            num = 64'(signed'(65'(k) - 65'(bp_key[h-1])));
                            den = 64'(signed'(65'(bp_key[h]) - 65'(bp_key[h-1])));
                            w = (den != 0) ? (num << 16) / den : 0;
                            r.weight = (w > 64'h10000) ? 17'h10000 : w[16:0];
                        end
                    end
                    r.lclip = bp_clip[r.lidx];
                    r.hclip = bp_clip[r.hidx];
                end
            end
        endcase
        r.count = 6'(bp_fill);
        return r;
    endfunction

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[OUT_W-1:0]);
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch exp %h got %h", want, got);
                end
            end
        end
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall);
    end

    op_t dir_ops [N_DIR];
    res_t dir_res [N_DIR];
    bit dir_chk [N_DIR];
    logic signed [31:0] rand_base [4];

    task automatic send_op(op_t op);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_TW'(op);
        pending_results.push_back(lookup_predict(op));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic op_t mk(logic [1:0] f, logic [31:0] k, logic [15:0] hd,
                               logic p, logic [5:0] s);
        op_t o;
        o.func = f; o.key = k; o.handle = hd; o.present = p; o.slot = s;
        return o;
    endfunction

    function automatic op_t rand_op(int mode);
        op_t o;
        int r;
        o.func = 2'($urandom_range(3));
        o.key = $urandom;
        o.handle = 16'($urandom);
        o.present = ($urandom_range(9) != 0);
        o.slot = 6'($urandom_range(63));
        r = $urandom_range(99);
        if (mode == 0 && r < 75) begin
            // keys from a small grid above a base to get replaces and blends
            o.key = rand_base[$urandom_range(3)] + 32'($urandom_range(40)) * 32'h3000;
            o.func = (r < 35) ? FUNC_ADD : (r < 70) ? FUNC_QUERY : FUNC_REMOVE;
            if (r < 70 && r >= 35 && $urandom_range(3) == 0) o.key = o.key + 32'($urandom_range(65535));
            o.slot = 6'($urandom_range(33));
        end
        if (o.func == FUNC_CLEAR && $urandom_range(3) != 0) o.func = FUNC_QUERY;
        return o;
    endfunction

    initial begin
        for (int i = 0; i < NE; i++) begin
            bp_key[i] = '0;
            bp_clip[i] = '0;
        end
        bp_fill = 0;
        dir_chk = '{default: 1'b0};
        dir_ops[0] = mk(FUNC_QUERY, 32'h0, 16'h0, 1'b0, 6'd0);
        dir_res[0] = '0; dir_chk[0] = 1;
        dir_ops[1] = mk(FUNC_REMOVE, 32'h0, 16'h0, 1'b0, 6'd0);
        dir_res[1] = '0; dir_res[1].status = ST_IGNORED; dir_chk[1] = 1;
        dir_ops[2] = mk(FUNC_ADD, 32'h5, 16'h1234, 1'b0, 6'd63);
        dir_res[2] = '0; dir_res[2].status = ST_IGNORED; dir_chk[2] = 1;
        dir_ops[3] = mk(FUNC_ADD, 32'h8000_0000, 16'hFFFF, 1'b1, 6'd0);
        dir_res[3] = '0; dir_res[3].count = 1; dir_chk[3] = 1;
        dir_ops[4] = mk(FUNC_ADD, 32'h7FFF_FFFF, 16'h0000, 1'b1, 6'd0);
        dir_ops[5] = mk(FUNC_QUERY, 32'h0, 16'h0, 1'b0, 6'd0);
        dir_ops[6] = mk(FUNC_QUERY, 32'h8000_0000, 16'h0, 1'b0, 6'd0);
        dir_ops[7] = mk(FUNC_QUERY, 32'h7FFF_FFFF, 16'h0, 1'b0, 6'd0);
        dir_ops[8] = mk(FUNC_ADD, 32'h0001_0000, 16'hAAAA, 1'b1, 6'd0);
        dir_ops[9] = mk(FUNC_QUERY, 32'h0001_0000, 16'h0, 1'b1, 6'd0);
        dir_ops[10] = mk(FUNC_ADD, 32'h0001_0000, 16'h5555, 1'b1, 6'd0);
        dir_ops[11] = mk(FUNC_QUERY, 32'h7FFF_FFFE, 16'h0, 1'b0, 6'd0);
        dir_ops[12] = mk(FUNC_QUERY, 32'h8000_0001, 16'h0, 1'b0, 6'd0);
        dir_ops[13] = mk(FUNC_REMOVE, 32'h0, 16'h0, 1'b0, 6'd1);
        dir_ops[14] = mk(FUNC_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 6'd2);
        dir_ops[15] = mk(FUNC_REMOVE, 32'h0, 16'h0, 1'b0, 6'd0);
        dir_ops[16] = mk(FUNC_QUERY, 32'h0, 16'h0, 1'b0, 6'd0);
        dir_ops[17] = mk(FUNC_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 6'd63);
        dir_res[17] = '0; dir_chk[17] = 1;
        dir_ops[18] = mk(FUNC_ADD, 32'h0, 16'h0001, 1'b1, 6'd0);
        dir_ops[19] = mk(FUNC_ADD, 32'h0000_0003, 16'h0002, 1'b1, 6'd0);
        dir_ops[20] = mk(FUNC_QUERY, 32'h0000_0001, 16'h0, 1'b0, 6'd0);
        dir_ops[21] = mk(FUNC_QUERY, 32'h0000_0002, 16'h0, 1'b0, 6'd0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIR; i++) begin
            send_op(dir_ops[i]);
            if (dir_chk[i] && pending_results[$] !== dir_res[i]) begin
                errors++;
                if (errors <= 10)
                    $display("row %0d exp %h pred %h", i, dir_res[i], pending_results[$]);
            end
        end
        // fill to capacity, then hit full and replace while full
        for (int i = 0; i < NE + 2; i++)
            send_op(mk(FUNC_ADD, 32'(i) * 32'h0002_0000 - 32'h0010_0000, 16'(i), 1'b1, 6'd0));
        send_op(mk(FUNC_ADD, 32'h0000_0000, 16'hBEEF, 1'b1, 6'd0));
        send_op(mk(FUNC_ADD, 32'hFFF0_8000, 16'hCAFE, 1'b1, 6'd0));
        send_op(mk(FUNC_QUERY, 32'h0000_8000, 16'h0, 1'b0, 6'd0));
        send_op(mk(FUNC_REMOVE, 32'h0, 16'h0, 1'b0, 6'd31));
        send_op(mk(FUNC_REMOVE, 32'h0, 16'h0, 1'b0, 6'd31));
        drain;

        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 56) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 56) : 0;
            for (int n = 0; n < 375; n++) begin
                if (n % 60 == 0)
                    for (int b = 0; b < 4; b++) rand_base[b] = $urandom;
                if (ph == 0 && n == 100) begin
                    fork
                        begin
                            hold_off = 1;
                            repeat (400) @(posedge aclk);
                            hold_off = 0;
                        end
                    join_none
                end
                if (n == 200) drain;
                send_op(rand_op(n % 7 == 6));
            end
        end

        drain;
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sbbl_pkg.sv
hw/rtl/sbbl_ram.sv
hw/rtl/sorted_breakpoint_blend_lookup.sv
hw/rtl/sbbl_chk.sv
tb/sorted_breakpoint_blend_lookup_tb.sv
